>>> src/usd_pkg.sv
// Shared types and codes of the upload stream deframer.
`timescale 1ns / 1ps

package usd_pkg;

    // Input kinds as they arrive on the stream.
    localparam logic [1:0] KIND_FLASH  = 2'd0;
    localparam logic [1:0] KIND_FILE   = 2'd1;
    localparam logic [1:0] KIND_BYTE   = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    // Result event codes.
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_NAME   = 3'd1;
    localparam logic [2:0] EV_HEADER = 3'd2;
    localparam logic [2:0] EV_DATA   = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NAME_LEN = 3'd1;
    localparam logic [2:0] ERR_LEN_TEXT = 3'd2;
    localparam logic [2:0] ERR_ZERO_LEN = 3'd3;
    localparam logic [2:0] ERR_SINK     = 3'd4;

    // Classified operation carried from front to back.
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_BYTE   = 2'd1,
        OP_REPORT = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       flash;
        logic [7:0] data;
        logic       ok;
    } t_cmd;

    // Deframer phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_NAME = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

endpackage

>>> src/usd_front.sv
// Front end of the deframer: input handshake, classification and a two-entry queue.
`timescale 1ns / 1ps

module usd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_stream_byte,
    input  logic          i_sink_ok,
    output logic          o_cmd_valid,
    output usd_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    localparam int DEPTH = 2;

    usd_pkg::t_cmd r_mem [DEPTH];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    usd_pkg::t_cmd w_cmd;
    logic          w_push;

    always_comb begin
        w_cmd.data  = i_stream_byte;
        w_cmd.ok    = i_sink_ok;
        w_cmd.flash = (i_kind == usd_pkg::KIND_FLASH);
        unique case (i_kind)
            usd_pkg::KIND_FLASH,
            usd_pkg::KIND_FILE:   w_cmd.op = usd_pkg::OP_START;
            usd_pkg::KIND_BYTE:   w_cmd.op = usd_pkg::OP_BYTE;
            usd_pkg::KIND_REPORT: w_cmd.op = usd_pkg::OP_REPORT;
            default:              w_cmd.op = usd_pkg::OP_REPORT;
        endcase
    end

    assign o_in_ready  = (r_count != 2'(DEPTH));
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ i_cmd_pop;
        n_count  = r_count + 2'(w_push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    // The back end never takes an entry from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != 2'd0))
        else $error("queue popped while empty");
`endif

endmodule

>>> src/usd_back.sv
// Back end of the deframer: phase state, length parsing, data offsets and the result register.
`timescale 1ns / 1ps

module usd_back #(
    parameter int PAGE_BYTES       = 256,
    parameter int NAME_MAX_CHARS   = 64,
    parameter int LENGTH_MAX_CHARS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  usd_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_event_res,
    output logic [7:0]    o_out_byte,
    output logic [31:0]   o_byte_offset,
    output logic [8:0]    o_commit_length,
    output logic [31:0]   o_transfer_length,
    output logic          o_to_flash,
    output logic          o_last_byte,
    output logic          o_launch,
    output logic [2:0]    o_error_code
);

    localparam int PAGE_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_BYTES - 1);

    usd_pkg::t_phase   r_phase, n_phase;
    logic              r_target, n_target;
    logic [31:0]       r_position, n_position;
    logic [31:0]       r_length, n_length;
    logic              r_digits_ended, n_digits_ended;
    logic [PAGE_W-1:0] r_page_pos, n_page_pos;

    logic              r_out_valid;
    logic [2:0]        r_event, n_event;
    logic [7:0]        r_byte, n_byte;
    logic [31:0]       r_offset, n_offset;
    logic [8:0]        r_commit, n_commit;
    logic [31:0]       r_xfer_len, n_xfer_len;
    logic              r_flash, r_last, n_last, r_launch, n_launch;
    logic [2:0]        r_err, n_err;

    logic [35:0]       w_times_ten;
    logic              w_is_digit;

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign w_is_digit  = (i_cmd.data >= 8'h30) && (i_cmd.data <= 8'h39);
    assign w_times_ten = ({4'd0, r_length} << 3) + ({4'd0, r_length} << 1)
                       + 36'(i_cmd.data[3:0]);

    always_comb begin
        n_phase        = r_phase;
        n_target       = r_target;
        n_position     = r_position;
        n_length       = r_length;
        n_digits_ended = r_digits_ended;
        n_page_pos     = r_page_pos;
        n_event        = usd_pkg::EV_NONE;
        n_byte         = 8'd0;
        n_offset       = 32'd0;
        n_commit       = 9'd0;
        n_xfer_len     = 32'd0;
        n_last         = 1'b0;
        n_launch       = 1'b0;
        n_err          = usd_pkg::ERR_NONE;

        unique case (i_cmd.op)
            usd_pkg::OP_START: begin
                n_target       = i_cmd.flash;
                n_phase        = usd_pkg::PH_NAME;
                n_position     = 32'd0;
                n_length       = 32'd0;
                n_digits_ended = 1'b0;
            end
            usd_pkg::OP_BYTE: begin
                unique case (r_phase)
                    usd_pkg::PH_NAME: begin
                        if (r_position >= 32'(NAME_MAX_CHARS)) begin
                            n_event = usd_pkg::EV_ERROR;
                            n_err   = usd_pkg::ERR_NAME_LEN;
                            n_phase = usd_pkg::PH_IDLE;
                        end else begin
                            n_event = usd_pkg::EV_NAME;
                            n_byte  = i_cmd.data;
                            if (i_cmd.data == 8'd0) begin
                                n_phase        = usd_pkg::PH_LEN;
                                n_position     = 32'd0;
                                n_length       = 32'd0;
                                n_digits_ended = 1'b0;
                            end else begin
                                n_position = r_position + 32'd1;
                            end
                        end
                    end
                    usd_pkg::PH_LEN: begin
                        if (r_position >= 32'(LENGTH_MAX_CHARS)) begin
                            n_event = usd_pkg::EV_ERROR;
                            n_err   = usd_pkg::ERR_LEN_TEXT;
                            n_phase = usd_pkg::PH_IDLE;
                        end else if (i_cmd.data == 8'd0) begin
                            if (r_length == 32'd0) begin
                                n_event = usd_pkg::EV_ERROR;
                                n_err   = usd_pkg::ERR_ZERO_LEN;
                                n_phase = usd_pkg::PH_IDLE;
                            end else begin
                                n_event    = usd_pkg::EV_HEADER;
                                n_xfer_len = r_length;
                                n_phase    = usd_pkg::PH_DATA;
                                n_position = 32'd0;
                                n_page_pos = '0;
                            end
                        end else begin
                            if (!r_digits_ended && w_is_digit) begin
                                n_length = (w_times_ten[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                         : w_times_ten[31:0];
                            end else begin
                                n_digits_ended = 1'b1;
                            end
                            n_position = r_position + 32'd1;
                        end
                    end
                    usd_pkg::PH_DATA: begin
                        if (r_position < r_length) begin
                            n_event  = usd_pkg::EV_DATA;
                            n_byte   = i_cmd.data;
                            n_offset = r_position;
                            if (r_position == r_length - 32'd1) begin
                                n_commit = 9'(32'(r_page_pos) + 32'd1);
                                n_last   = 1'b1;
                            end else if (r_page_pos == PAGE_LAST) begin
                                n_commit = 9'(PAGE_BYTES);
                            end
                            n_position = r_position + 32'd1;
                            n_page_pos = (r_page_pos == PAGE_LAST) ? '0
                                                                   : r_page_pos + PAGE_W'(1);
                        end
                    end
                    default: begin
                        // Idle: stray bytes are dropped with an empty result.
                    end
                endcase
            end
            usd_pkg::OP_REPORT: begin
                if (r_phase == usd_pkg::PH_DATA) begin
                    if (!i_cmd.ok) begin
                        n_event = usd_pkg::EV_ERROR;
                        n_err   = usd_pkg::ERR_SINK;
                        n_phase = usd_pkg::PH_IDLE;
                    end else if (r_position == r_length) begin
                        n_launch       = r_target;
                        n_phase        = usd_pkg::PH_IDLE;
                        n_position     = 32'd0;
                        n_length       = 32'd0;
                        n_digits_ended = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        // Every error clears the parse state on its way back to idle.
        if (n_event == usd_pkg::EV_ERROR) begin
            n_position     = 32'd0;
            n_length       = 32'd0;
            n_digits_ended = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= usd_pkg::PH_IDLE;
            r_target       <= 1'b0;
            r_position     <= 32'd0;
            r_length       <= 32'd0;
            r_digits_ended <= 1'b0;
            r_page_pos     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_phase        <= n_phase;
                r_target       <= n_target;
                r_position     <= n_position;
                r_length       <= n_length;
                r_digits_ended <= n_digits_ended;
                r_page_pos     <= n_page_pos;
            end
            if (o_cmd_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_event    <= n_event;
            r_byte     <= n_byte;
            r_offset   <= n_offset;
            r_commit   <= n_commit;
            r_xfer_len <= n_xfer_len;
            r_flash    <= n_target;
            r_last     <= n_last;
            r_launch   <= n_launch;
            r_err      <= n_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_res       = r_event;
    assign o_out_byte        = r_byte;
    assign o_byte_offset     = r_offset;
    assign o_commit_length   = r_commit;
    assign o_transfer_length = r_xfer_len;
    assign o_to_flash        = r_flash;
    assign o_last_byte       = r_last;
    assign o_launch          = r_launch;
    assign o_error_code      = r_err;

`ifndef NO_ASSERTIONS
    // The data offset never runs past the parsed length.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == usd_pkg::PH_DATA) |-> (r_position <= r_length))
        else $error("data position beyond transfer length");

    // An error result always leaves the deframer idle.
    a_error_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && (n_event == usd_pkg::EV_ERROR)) |=> (r_phase == usd_pkg::PH_IDLE))
        else $error("error did not return the deframer to idle");

    // Launch comes only with an empty event and only for a flash target.
    a_launch_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_launch) |-> ((r_event == usd_pkg::EV_NONE) && r_flash))
        else $error("launch raised with a non-empty event");
`endif

endmodule

>>> src/upload_stream_deframer_unit.sv
// Top level of the upload stream deframer: front queue and back-end executor.
`timescale 1ns / 1ps

// The deframer takes one beat per clock cycle while its queue has room and
// gives exactly one result beat for every input beat. A start beat (flash or
// file) opens a transfer; stream bytes then carry a zero-terminated name, which
// comes out one character at a time, a zero-terminated decimal length that
// saturates at 2^32-1, and exactly that many data bytes, each with its offset
// and, at a page end or the final byte, a commit length. A failed sink report,
// an over-long name or length text, or a zero length gives an error result and
// drops back to idle. A successful report after the final byte ends the
// transfer, with launch set for a flash target. Throughput is one beat per
// cycle when the output side is not stalled, set by the back end updating its
// state for each beat it takes. An accepted beat is written into the queue,
// and the back end then loads its result into the output register, from which
// the result beat is taken. A two-entry queue between the front and back ends
// lets input and output stall independently.

module upload_stream_deframer_unit #(
    parameter int PAGE_BYTES       = 256,
    parameter int NAME_MAX_CHARS   = 64,
    parameter int LENGTH_MAX_CHARS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_sink_ok,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_byte_offset,
    output logic [8:0]  o_commit_length,
    output logic [31:0] o_transfer_length,
    output logic        o_to_flash,
    output logic        o_last_byte,
    output logic        o_launch,
    output logic [2:0]  o_error_code
);

    // Classified beats travel from the queue to the executor as one struct.
    logic          w_cmd_valid;
    logic          w_cmd_pop;
    usd_pkg::t_cmd w_cmd;

    usd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_stream_byte (i_stream_byte),
        .i_sink_ok     (i_sink_ok),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    // The back end owns all phase state and the registered result beat.
    usd_back #(
        .PAGE_BYTES       (PAGE_BYTES),
        .NAME_MAX_CHARS   (NAME_MAX_CHARS),
        .LENGTH_MAX_CHARS (LENGTH_MAX_CHARS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (w_cmd_valid),
        .i_cmd             (w_cmd),
        .o_cmd_pop         (w_cmd_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_event_res       (o_event_res),
        .o_out_byte        (o_out_byte),
        .o_byte_offset     (o_byte_offset),
        .o_commit_length   (o_commit_length),
        .o_transfer_length (o_transfer_length),
        .o_to_flash        (o_to_flash),
        .o_last_byte       (o_last_byte),
        .o_launch          (o_launch),
        .o_error_code      (o_error_code)
    );

endmodule
